/* hdl/cslru_pkg.sv */
// ----------------------------------------------------------------------------
// cslru_pkg: shared types and constants for the client slot LRU scheduler
// Request and result beat layouts, request codes and status codes.
// ----------------------------------------------------------------------------
package cslru_pkg;

    localparam int MAX_CLIENTS_DEF = 16;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_GRANT  = 2'd2;
    localparam logic [1:0] REQ_FIND   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  slot_index;
        logic [15:0] eligible_mask;
        logic [31:0] lookup_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic [31:0] uid_out;
        logic [4:0]  client_count;
    } t_res;

endpackage

/* hdl/client_slot_lru_scheduler_core.sv */
// ----------------------------------------------------------------------------
// client_slot_lru_scheduler_core: least-recently-served client slot arbiter
// Compact client slot table plus a service order list, both held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req and raise start; the beat is taken on a
//   clock edge where start is high and busy is low. busy stays high while a
//   request walks the tables.
//   Result channel: o_res is valid for exactly one cycle while o_strobe is
//   high. The receiver cannot stall; it must take the beat in that cycle.
//   Every request yields exactly one result beat.
//   Steps per request (n = slots in use):
//     add, remove of a bad slot, grant or find on an empty table: answered from idle.
//     find: one slot id read per cycle until hit, overshoot or table end.
//     grant: scan up to n entries, then shift the tail of the order list
//       down one entry per cycle and write the winner last, or answer none
//       when no slot is eligible.
//     remove (slot k): move the ids above k down one slot, then pass once
//       over the order list, dropping k and renumbering the slots above it.
//   A new request is taken in the cycle the previous result is strobed.
//   Reset clears the slot count to zero and the id seed to one; the RAMs
//   are not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module client_slot_lru_scheduler_core #(
    parameter int MAX_CLIENTS = cslru_pkg::MAX_CLIENTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cslru_pkg::t_req i_req,
    output logic            o_strobe,
    output cslru_pkg::t_res o_res
);

    localparam int SlotW = $clog2(MAX_CLIENTS);
    localparam int CntW  = $clog2(MAX_CLIENTS + 1);

    // one-hot sequencer states
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,  // wait for a request
        S_FIND = 8'b0000_0010,  // scan slot ids in slot order
        S_RMG  = 8'b0000_0100,  // capture id of the removed slot
        S_RMU  = 8'b0000_1000,  // close the gap in the id table
        S_RMO  = 8'b0001_0000,  // compact and renumber the order list
        S_GSC  = 8'b0010_0000,  // scan order list for first eligible slot
        S_GSH  = 8'b0100_0000,  // shift order entries behind the winner
        S_GTL  = 8'b1000_0000   // put the winner at the tail
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [31:0]     r_next_uid, n_next_uid;
    cslru_pkg::t_req r_req, n_req;
    logic [SlotW-1:0] r_idx, n_idx;
    logic [SlotW-1:0] r_w, n_w;
    logic            r_found, n_found;
    logic [SlotW-1:0] r_tmp, n_tmp;
    logic [31:0]     r_gone, n_gone;
    cslru_pkg::t_res r_res, n_res;
    logic            r_strobe, n_strobe;

    // RAM ports
    logic             uid_we;
    logic [SlotW-1:0] uid_waddr, uid_raddr;
    logic [31:0]      uid_wdata, uid_rdata;
    logic             ord_we;
    logic [SlotW-1:0] ord_waddr, ord_raddr;
    logic [SlotW-1:0] ord_wdata, ord_rdata;

    // scan helpers
    logic             last;
    logic [SlotW-1:0] idx_inc;
    logic [SlotW-1:0] rm_slot;
    logic [31:0]      ord_ext;
    logic             elig;

    function automatic cslru_pkg::t_res mk_res(input logic [1:0]  st,
                                              input logic [3:0]  slot,
                                              input logic [31:0] uid,
                                              input logic [4:0]  cnt);
        cslru_pkg::t_res res;
        res.status       = st;
        res.slot_out     = slot;
        res.uid_out      = uid;
        res.client_count = cnt;
        return res;
    endfunction

    cslru_ram #(
        .WIDTH (32),
        .DEPTH (MAX_CLIENTS)
    ) u_uid_ram (
        .i_clk   (i_clk),
        .i_we    (uid_we),
        .i_waddr (uid_waddr),
        .i_wdata (uid_wdata),
        .i_raddr (uid_raddr),
        .o_rdata (uid_rdata)
    );

    cslru_ram #(
        .WIDTH (SlotW),
        .DEPTH (MAX_CLIENTS)
    ) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // the entry on the read port is the last one in use
    assign last    = ((CntW'(r_idx) + CntW'(1)) >= r_cnt);
    assign idx_inc = r_idx + SlotW'(1);
    assign rm_slot = SlotW'(r_req.slot_index);
    assign ord_ext = 32'(ord_rdata);
    // slots numbered 16 or more never see a mask bit
    assign elig    = (ord_ext < 32'd16) && r_req.eligible_mask[ord_ext[3:0]];

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_next_uid = r_next_uid;
        n_req      = r_req;
        n_idx      = r_idx;
        n_w        = r_w;
        n_found    = r_found;
        n_tmp      = r_tmp;
        n_gone     = r_gone;
        n_res      = r_res;
        n_strobe   = 1'b0;

        uid_we    = 1'b0;
        uid_waddr = r_idx;
        uid_wdata = uid_rdata;
        uid_raddr = idx_inc;
        ord_we    = 1'b0;
        ord_waddr = r_w;
        ord_wdata = ord_rdata;
        ord_raddr = idx_inc;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    case (i_req.req_type)
                        cslru_pkg::REQ_ADD: begin
                            if (r_cnt >= CntW'(MAX_CLIENTS)) begin
                                n_res = mk_res(cslru_pkg::ST_FULL, 4'd0, 32'd0,
                                               5'(r_cnt));
                            end else begin
                                // append at the table end and the order tail
                                uid_we     = 1'b1;
                                uid_waddr  = SlotW'(r_cnt);
                                uid_wdata  = r_next_uid;
                                ord_we     = 1'b1;
                                ord_waddr  = SlotW'(r_cnt);
                                ord_wdata  = SlotW'(r_cnt);
                                n_cnt      = r_cnt + CntW'(1);
                                n_next_uid = (r_next_uid == 32'hFFFF_FFFF) ? 32'd1
                                                                           : r_next_uid + 32'd1;
                                n_res = mk_res(cslru_pkg::ST_OK, 4'(r_cnt), r_next_uid,
                                               5'(r_cnt + CntW'(1)));
                            end
                            n_strobe = 1'b1;
                        end
                        cslru_pkg::REQ_REMOVE: begin
                            if (32'(i_req.slot_index) >= 32'(r_cnt)) begin
                                n_res    = mk_res(cslru_pkg::ST_BAD, 4'd0, 32'd0,
                                                  5'(r_cnt));
                                n_strobe = 1'b1;
                            end else begin
                                uid_raddr = SlotW'(i_req.slot_index);
                                n_idx     = SlotW'(i_req.slot_index);
                                n_state   = S_RMG;
                            end
                        end
                        cslru_pkg::REQ_GRANT: begin
                            if (r_cnt == '0) begin
                                n_res    = mk_res(cslru_pkg::ST_NONE, 4'd0, 32'd0, 5'd0);
                                n_strobe = 1'b1;
                            end else begin
                                ord_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_GSC;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_res    = mk_res(cslru_pkg::ST_NONE, 4'd0, 32'd0, 5'd0);
                                n_strobe = 1'b1;
                            end else begin
                                uid_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_FIND;
                            end
                        end
                    endcase
                end
            end

            S_FIND: begin
                // hit, overshoot of an ordered id, or end of table
                if (uid_rdata == r_req.lookup_id) begin
                    n_res    = mk_res(cslru_pkg::ST_OK, 4'(r_idx), r_req.lookup_id,
                                      5'(r_cnt));
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (uid_rdata > r_req.lookup_id || last) begin
                    n_res    = mk_res(cslru_pkg::ST_NONE, 4'd0, 32'd0, 5'(r_cnt));
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = idx_inc;
                end
            end

            S_RMG: begin
                n_gone = uid_rdata;
                if (last) begin
                    ord_raddr = '0;
                    n_idx     = '0;
                    n_w       = '0;
                    n_found   = 1'b0;
                    n_state   = S_RMO;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_RMU;
                end
            end

            S_RMU: begin
                // move each id one slot down
                uid_we    = 1'b1;
                uid_waddr = r_idx - SlotW'(1);
                uid_wdata = uid_rdata;
                if (last) begin
                    ord_raddr = '0;
                    n_idx     = '0;
                    n_w       = '0;
                    n_found   = 1'b0;
                    n_state   = S_RMO;
                end else begin
                    n_idx = idx_inc;
                end
            end

            S_RMO: begin
                // drop the removed slot, renumber the ones above it
                if (!r_found && ord_rdata == rm_slot) begin
                    n_found = 1'b1;
                end else if ((CntW'(r_w) + CntW'(1)) < r_cnt) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_w;
                    ord_wdata = (ord_rdata > rm_slot) ? ord_rdata - SlotW'(1) : ord_rdata;
                    n_w       = r_w + SlotW'(1);
                end
                if (last) begin
                    n_cnt    = r_cnt - CntW'(1);
                    n_res    = mk_res(cslru_pkg::ST_OK, r_req.slot_index, r_gone,
                                      5'(r_cnt - CntW'(1)));
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = idx_inc;
                end
            end

            S_GSC: begin
                if (elig) begin
                    // fetch the winner's id while the order list shifts
                    n_tmp     = ord_rdata;
                    uid_raddr = ord_rdata;
                    if (last) begin
                        n_state = S_GTL;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_GSH;
                    end
                end else if (last) begin
                    n_res    = mk_res(cslru_pkg::ST_NONE, 4'd0, 32'd0, 5'(r_cnt));
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = idx_inc;
                end
            end

            S_GSH: begin
                uid_raddr = r_tmp;
                ord_we    = 1'b1;
                ord_waddr = r_idx - SlotW'(1);
                ord_wdata = ord_rdata;
                if (last) begin
                    n_state = S_GTL;
                end else begin
                    n_idx = idx_inc;
                end
            end

            S_GTL: begin
                uid_raddr = r_tmp;
                ord_we    = 1'b1;
                ord_waddr = SlotW'(r_cnt - CntW'(1));
                ord_wdata = r_tmp;
                n_res     = mk_res(cslru_pkg::ST_OK, 4'(r_tmp), uid_rdata, 5'(r_cnt));
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_next_uid <= 32'd1;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_next_uid <= n_next_uid;
            r_strobe   <= n_strobe;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_w     <= n_w;
        r_found <= n_found;
        r_tmp   <= n_tmp;
        r_gone  <= n_gone;
        r_res   <= n_res;
    end

endmodule

/* hdl/cslru_ram.sv */
// ----------------------------------------------------------------------------
// cslru_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cslru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = cslru_pkg::MAX_CLIENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
